@@ rtl/core/sbc_pkg.sv @@
// Shared types and constants for the segment/box clipper.
// No dependencies; imported by every module of the block.
`default_nettype none
package sbc_pkg;

    localparam int unsigned VAL_W = 32;
    localparam int unsigned EXT_W = 31;
    localparam int unsigned AXES  = 3;

    // One segment as it travels down the row of plane cells.
    typedef struct packed {
        logic                               alive;
        logic signed [VAL_W-1:0]            t0;
        logic signed [VAL_W-1:0]            t1;
        logic signed [VAL_W-1:0]            s0;
        logic signed [VAL_W-1:0]            s1;
        logic [AXES-1:0][VAL_W-1:0]         org;
        logic [AXES-1:0][VAL_W-1:0]         dir;
        logic [AXES-1:0][EXT_W-1:0]         ext;
    } item_t;

    // Control that rides along the divider steps of one cell.
    typedef struct packed {
        logic valid;
        logic upd;
        logic to_end;
        logic neg;
    } ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/sbc_div_step.sv @@
// One restoring-division step: one quotient bit per stage.
// Depends on sbc_pkg.
`default_nettype none
module sbc_div_step #(
    parameter int unsigned MW  = 50,
    parameter int unsigned BIT = 0
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire sbc_pkg::ctl_t          ctl_i,
    input  wire sbc_pkg::item_t         item_i,
    input  wire logic [31:0]            rem_i,
    input  wire logic [31:0]            quo_i,
    input  wire logic [31:0]            dsr_i,
    input  wire logic [MW-1:0]          dvd_i,
    output sbc_pkg::ctl_t               ctl_o,
    output sbc_pkg::item_t              item_o,
    output logic [31:0]                 rem_o,
    output logic [31:0]                 quo_o,
    output logic [31:0]                 dsr_o,
    output logic [MW-1:0]               dvd_o
);
    import sbc_pkg::*;

    logic [32:0] sh;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] rem_next;
    logic [31:0] quo_next;

    // Shift in the next dividend bit and subtract the divisor if it fits.
    always_comb
    begin
        sh       = {rem_i, dvd_i[BIT]};
        diff     = sh - {1'b0, dsr_i};
        ge       = (sh >= {1'b0, dsr_i});
        rem_next = ge ? diff[31:0] : sh[31:0];
        quo_next = quo_i;
        quo_next[BIT] = ge;
    end

    // Control is reset; the payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_o <= '0;
        end
        else if (en)
        begin
            ctl_o <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_o <= item_i;
            rem_o  <= rem_next;
            quo_o  <= quo_next;
            dsr_o  <= dsr_i;
            dvd_o  <= dvd_i;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/sbc_plane_cell.sv @@
// One box plane: bound tests, pipelined quotient and interval update.
// Depends on sbc_pkg and sbc_div_step.
`default_nettype none
module sbc_plane_cell #(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned AXIS      = 0,
    parameter bit          NEG       = 1'b0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire sbc_pkg::item_t     in_item,
    output logic                    out_valid,
    output sbc_pkg::item_t          out_item
);
    import sbc_pkg::*;

    localparam int unsigned SW = FRAC_BITS + 34;
    localparam int unsigned CW = (SW > 65) ? SW : 65;

    // Stage A: plane numerator, denominator and the two products.
    logic signed [32:0]     dir_e;
    logic signed [32:0]     d_a;
    logic signed [33:0]     org_e;
    logic signed [33:0]     ext_e;
    logic signed [33:0]     numer;
    logic signed [31:0]     tr;
    logic signed [31:0]     tu;
    logic signed [64:0]     pr_a;
    logic signed [64:0]     pu_a;

    always_comb
    begin
        dir_e = {in_item.dir[AXIS][31], in_item.dir[AXIS]};
        d_a   = NEG ? -dir_e : dir_e;
        org_e = {{2{in_item.org[AXIS][31]}}, in_item.org[AXIS]};
        ext_e = {3'b000, in_item.ext[AXIS]};
        numer = NEG ? (org_e - ext_e) : (-org_e - ext_e);
        tr    = d_a[32] ? in_item.t0 : in_item.t1;
        tu    = d_a[32] ? in_item.t1 : in_item.t0;
        pr_a  = d_a * tr;
        pu_a  = d_a * tu;
    end

    logic                   vld_a_reg;
    item_t                  item_a_reg;
    logic signed [SW-1:0]   sc_a_reg;
    logic signed [32:0]     d_a_reg;
    logic signed [64:0]     pr_a_reg;
    logic signed [64:0]     pu_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_a_reg <= in_item;
            sc_a_reg   <= {numer, {FRAC_BITS{1'b0}}};
            d_a_reg    <= d_a;
            pr_a_reg   <= pr_a;
            pu_a_reg   <= pu_a;
        end
    end

    // Stage B: reject and update decisions, operand magnitudes.
    logic signed [CW-1:0]   scc;
    logic signed [CW-1:0]   prc;
    logic signed [CW-1:0]   puc;
    logic                   rej;
    ctl_t                   ctl_b;
    item_t                  item_b;
    logic [SW-1:0]          mag_b;
    logic signed [32:0]     dneg;
    logic [31:0]            dmag_b;

    always_comb
    begin
        scc          = CW'(sc_a_reg);
        prc          = CW'(pr_a_reg);
        puc          = CW'(pu_a_reg);
        rej          = item_a_reg.alive && (scc > prc);
        item_b       = item_a_reg;
        item_b.alive = item_a_reg.alive && !rej;
        ctl_b.valid  = vld_a_reg;
        ctl_b.upd    = item_a_reg.alive && !rej && (scc > puc);
        ctl_b.to_end = d_a_reg[32];
        ctl_b.neg    = sc_a_reg[SW-1] ^ d_a_reg[32];
        mag_b        = sc_a_reg[SW-1] ? SW'(-sc_a_reg) : SW'(sc_a_reg);
        dneg         = -d_a_reg;
        dmag_b       = d_a_reg[32] ? dneg[31:0] : d_a_reg[31:0];
    end

    // Divider pipeline, one quotient bit per step, top bit first.
    ctl_t           ctl_s  [0:32];
    item_t          item_s [0:32];
    logic [31:0]    rem_s  [0:32];
    logic [31:0]    quo_s  [0:32];
    logic [31:0]    dsr_s  [0:32];
    logic [SW-1:0]  dvd_s  [0:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_s[0] <= '0;
        end
        else if (en)
        begin
            ctl_s[0] <= ctl_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_s[0] <= item_b;
            rem_s[0]  <= 32'(mag_b >> 32);
            quo_s[0]  <= '0;
            dsr_s[0]  <= dmag_b;
            dvd_s[0]  <= mag_b;
        end
    end

    for (genvar i = 0; i < 32; i++)
    begin : g_step
        sbc_div_step #(
            .MW  (SW),
            .BIT (31 - i)
        ) u_step (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .ctl_i  (ctl_s[i]),
            .item_i (item_s[i]),
            .rem_i  (rem_s[i]),
            .quo_i  (quo_s[i]),
            .dsr_i  (dsr_s[i]),
            .dvd_i  (dvd_s[i]),
            .ctl_o  (ctl_s[i+1]),
            .item_o (item_s[i+1]),
            .rem_o  (rem_s[i+1]),
            .quo_o  (quo_s[i+1]),
            .dsr_o  (dsr_s[i+1]),
            .dvd_o  (dvd_s[i+1])
        );
    end

    // Final stage: sign the quotient and write it into the chosen bound.
    logic [31:0]    qs;
    item_t          item_f;

    always_comb
    begin
        qs     = ctl_s[32].neg ? (32'd0 - quo_s[32]) : quo_s[32];
        item_f = item_s[32];
        if (ctl_s[32].upd)
        begin
            if (ctl_s[32].to_end)
            begin
                item_f.t1 = qs;
            end
            else
            begin
                item_f.t0 = qs;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= ctl_s[32].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_item <= item_f;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/segment_box_clip.sv @@
// Top level of the segment/box clipper: six plane cells in a row.
// Depends on sbc_pkg and sbc_plane_cell.
//
// Clips the parameter interval of a segment against a box centred at the
// origin, planes taken in the order x-, x+, y-, y+, z-, z+. One beat is
// accepted every cycle while in_stall is low, and each gives one result
// beat; each plane cell has a stage for its products, one for its bound
// tests, a division pipeline that yields one quotient bit per step and one
// for the update. All stages advance together, so a stalled output beat
// holds the whole row and in_stall is raised until it is taken.
`default_nettype none
module segment_box_clip #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic signed [31:0]     origin_x,
    input  wire logic signed [31:0]     origin_y,
    input  wire logic signed [31:0]     origin_z,
    input  wire logic signed [31:0]     dir_x,
    input  wire logic signed [31:0]     dir_y,
    input  wire logic signed [31:0]     dir_z,
    input  wire logic [30:0]            half_ext_x,
    input  wire logic [30:0]            half_ext_y,
    input  wire logic [30:0]            half_ext_z,
    input  wire logic signed [31:0]     t_start_in,
    input  wire logic signed [31:0]     t_end_in,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        hit,
    output logic signed [31:0]          t_start_out,
    output logic signed [31:0]          t_end_out
);
    import sbc_pkg::*;

    logic   en;
    logic   vld  [0:6];
    item_t  itm  [0:6];

    // The row moves unless the result beat at its end is held.
    assign en       = !(vld[6] && out_stall);
    assign in_stall = !en;

    // Gather the input beat into one item.
    always_comb
    begin
        itm[0].alive  = 1'b1;
        itm[0].t0     = t_start_in;
        itm[0].t1     = t_end_in;
        itm[0].s0     = t_start_in;
        itm[0].s1     = t_end_in;
        itm[0].org[0] = origin_x;
        itm[0].org[1] = origin_y;
        itm[0].org[2] = origin_z;
        itm[0].dir[0] = dir_x;
        itm[0].dir[1] = dir_y;
        itm[0].dir[2] = dir_z;
        itm[0].ext[0] = half_ext_x;
        itm[0].ext[1] = half_ext_y;
        itm[0].ext[2] = half_ext_z;
    end
    assign vld[0] = in_valid;

    for (genvar p = 0; p < 6; p++)
    begin : g_plane
        sbc_plane_cell #(
            .FRAC_BITS (FRAC_BITS),
            .AXIS      (p / 2),
            .NEG       (p % 2 == 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld[p]),
            .in_item   (itm[p]),
            .out_valid (vld[p+1]),
            .out_item  (itm[p+1])
        );
    end

    // Result beat straight from the last cell's register.
    assign out_valid   = vld[6];
    assign t_start_out = itm[6].t0;
    assign t_end_out   = itm[6].t1;
    assign hit         = itm[6].alive && ((itm[6].t0 != itm[6].s0) ||
                                          (itm[6].t1 != itm[6].s1));

    // Input is held off only while a finished beat waits at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // A held result beat is not dropped by the row.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(t_end_out)))
        else $error("held result beat lost");

    // A rejected segment never reports a hit.
    a_hit_alive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !itm[6].alive) |-> !hit)
        else $error("hit raised on a clipped-away segment");

endmodule
`default_nettype wire
